// File: rtl/cbyuv_pkg.sv
// cbyuv_pkg: request and response types, chroma coefficients and helpers
// for the codebook YCbCr to RGBA converter; no dependencies
package cbyuv_pkg;

   typedef struct packed {
      logic [7:0] luma_0;
      logic [7:0] luma_1;
      logic [7:0] luma_2;
      logic [7:0] luma_3;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
   } req_data_type;

   typedef struct packed {
      logic [31:0] pixel_0;
      logic [31:0] pixel_1;
      logic [31:0] pixel_2;
      logic [31:0] pixel_3;
   } rsp_data_type;

   localparam int unsigned COEF_WIDTH = 25;
   localparam int unsigned COEF_SHIFT = 24;

   // ceil(k * 2^24); the excess over the exact ratio stays below the
   // spacing of the exact fractional parts, so the floor is exact
   localparam logic [COEF_WIDTH-1:0] COEF_VR = 25'd23521657;  // 1.402
   localparam logic [COEF_WIDTH-1:0] COEF_UG = 25'd5773712;   // 0.34414
   localparam logic [COEF_WIDTH-1:0] COEF_VG = 25'd11981282;  // 0.71414
   localparam logic [COEF_WIDTH-1:0] COEF_UB = 25'd29729227;  // 1.772

   localparam logic [7:0] CHROMA_OFFSET = 8'd128;
   localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

   // trunc((chroma - 128) * coef) toward zero, signed 9 bits
   function automatic logic signed [8:0] chroma_term(input logic [7:0] chroma,
                                                     input logic [COEF_WIDTH-1:0] coef);
      logic                  neg;
      logic [7:0]            mag;
      logic [COEF_WIDTH+7:0] prod;
      logic [7:0]            qmag;
      neg  = (chroma < CHROMA_OFFSET);
      mag  = neg ? (CHROMA_OFFSET - chroma) : (chroma - CHROMA_OFFSET);
      prod = {{COEF_WIDTH{1'b0}}, mag} * {8'd0, coef};
      qmag = prod[COEF_SHIFT+7:COEF_SHIFT];
      return neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
   endfunction

   // clamp a channel sum to 0..255
   function automatic logic [7:0] sat_byte(input logic signed [10:0] v);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v > 11'sd255) begin
         r = 8'hFF;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // one RGBA word from a luma byte and the shared chroma terms
   function automatic logic [31:0] make_pixel(input logic [7:0] luma,
                                              input logic signed [8:0] rt,
                                              input logic signed [9:0] gt,
                                              input logic signed [8:0] bt);
      logic signed [10:0] y;
      logic signed [10:0] rs;
      logic signed [10:0] gs;
      logic signed [10:0] bs;
      y  = $signed({3'b000, luma});
      rs = y + 11'(rt);
      gs = y - 11'(gt);
      bs = y + 11'(bt);
      return {ALPHA_OPAQUE, sat_byte(bs), sat_byte(gs), sat_byte(rs)};
   endfunction

endpackage

// File: rtl/codebook_yuv_to_rgba_top.sv
// codebook_yuv_to_rgba_top: converts one 2x2 codebook entry (four luma,
// one shared chroma pair) into four packed RGBA pixels; uses cbyuv_pkg
//
//   channel  | direction | payload        | handshake
//   ---------+-----------+----------------+------------------------
//   req_     | in        | req_data_type  | req_valid / req_ready
//   rsp_     | out       | rsp_data_type  | rsp_valid / rsp_ready
//
// one request per cycle sustained while rsp_ready is not held low; a result
// passes the input register and then the result register before rsp_valid
// the rate is set by the single conversion pass between the two registers
// reset clears both valid flags; data registers are not reset
// a stalled result holds in the result register while the input register
// still takes one more request; the input side stalls only when both are full
module codebook_yuv_to_rgba_top
   import cbyuv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   // input register
   logic         in_valid_ff;
   logic         in_valid_in;
   req_data_type in_data_ff;

   // result register
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_data_type out_data_ff;
   rsp_data_type out_data_in;

   logic         out_load;   // result register may take a new value
   logic         req_accept;

   // chroma terms shared by the four pixels
   logic signed [8:0] vr_term;
   logic signed [8:0] ug_term;
   logic signed [8:0] vg_term;
   logic signed [8:0] ub_term;
   logic signed [9:0] g_term;

   assign out_load   = !out_valid_ff || rsp_ready;
   assign req_ready  = !in_valid_ff || out_load;
   assign req_accept = req_valid && req_ready;

   // input stage refills whenever it empties or moves forward
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   // result stage loads from the input stage when free or being drained
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
   end

   // conversion pass
   always_comb begin
      vr_term = chroma_term(in_data_ff.chroma_v, COEF_VR);
      ug_term = chroma_term(in_data_ff.chroma_u, COEF_UG);
      vg_term = chroma_term(in_data_ff.chroma_v, COEF_VG);
      ub_term = chroma_term(in_data_ff.chroma_u, COEF_UB);
      g_term  = 10'(ug_term) + 10'(vg_term);
      out_data_in.pixel_0 = make_pixel(in_data_ff.luma_0, vr_term, g_term, ub_term);
      out_data_in.pixel_1 = make_pixel(in_data_ff.luma_1, vr_term, g_term, ub_term);
      out_data_in.pixel_2 = make_pixel(in_data_ff.luma_2, vr_term, g_term, ub_term);
      out_data_in.pixel_3 = make_pixel(in_data_ff.luma_3, vr_term, g_term, ub_term);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (out_load && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // an accepted request always lands in the input register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted request not held in input register");

   // a held item moves to the result register whenever that is free
   a_item_advances: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_load) |=> out_valid_ff)
      else $error("item lost between input and result registers");

   // an empty input register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("request side stalled with empty input register");

   // alpha of every delivered pixel is opaque
   a_alpha_opaque: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.pixel_0[31:24] == ALPHA_OPAQUE &&
                        out_data_ff.pixel_1[31:24] == ALPHA_OPAQUE &&
                        out_data_ff.pixel_2[31:24] == ALPHA_OPAQUE &&
                        out_data_ff.pixel_3[31:24] == ALPHA_OPAQUE))
      else $error("result alpha not opaque");

endmodule
